// ----- design/cia_pkg.sv -----
// Shared types and constants for the chained integer ALU.
package cia_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = 5;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4,
		OP_POW = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic short_op;
	} dp_sts_t;

endpackage

// ----- design/cia_dp.sv -----
// Datapath: operands, shared multiplier, squarer, restoring divider and result register.
module cia_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cia_pkg::dp_cmd_t               cmd,
	output cia_pkg::dp_sts_t               sts,
	input  logic [2:0]                     opcode,
	input  logic signed [cia_pkg::DATA_W-1:0] operand_a,
	input  logic signed [cia_pkg::DATA_W-1:0] operand_b,
	input  logic                           chain,
	output logic signed [cia_pkg::DATA_W-1:0] result,
	output logic                           div_by_zero,
	output logic                           reciprocal
);

	localparam int unsigned W = cia_pkg::DATA_W;

	function automatic logic [W-1:0] abs_mag(input logic [W-1:0] v);
		abs_mag = v[W-1] ? (~v + W'(1)) : v;
	endfunction

	logic [2:0]   op_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic         a_neg_q;
	logic         b_neg_q;
	logic         dz_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] base_q;
	logic [W-1:0] mag_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] last_q;
	logic [W-1:0] res_q;
	logic         res_dz_q;
	logic         res_rc_q;

	logic [W-1:0]   a_sel;
	logic [W-1:0]   mul_sel;
	logic [2*W-1:0] prod;
	logic [2*W-1:0] sq;
	logic [W:0]     shifted;
	logic [W:0]     trial;
	logic [W-1:0]   res_d;
	logic           op_valid;

	assign a_sel   = chain ? last_q : operand_a;
	assign mul_sel = (op_q == cia_pkg::OP_MUL) ? b_q : base_q;
	assign prod    = {{W{1'b0}}, acc_q} * {{W{1'b0}}, mul_sel};
	assign sq      = {{W{1'b0}}, base_q} * {{W{1'b0}}, base_q};
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, mag_q};

	always_comb begin
		sts.short_op = 1'b1;
		unique case (op_q)
			cia_pkg::OP_DIV, cia_pkg::OP_REM, cia_pkg::OP_POW: sts.short_op = dz_q;
			default: sts.short_op = 1'b1;
		endcase
	end

	always_comb begin
		res_d    = last_q;
		op_valid = 1'b1;
		unique case (op_q)
			cia_pkg::OP_ADD: res_d = a_q + b_q;
			cia_pkg::OP_SUB: res_d = a_q - b_q;
			cia_pkg::OP_MUL: res_d = acc_q;
			cia_pkg::OP_DIV: begin
				if (dz_q)
					res_d = '0;
				else
					res_d = (a_neg_q != b_neg_q) ? (~quo_q + W'(1)) : quo_q;
			end
			cia_pkg::OP_REM: begin
				if (dz_q)
					res_d = '0;
				else
					res_d = a_neg_q ? (~rem_q + W'(1)) : rem_q;
			end
			cia_pkg::OP_POW: res_d = acc_q;
			default: begin
				res_d    = last_q;
				op_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			a_q     <= a_sel;
			b_q     <= operand_b;
			a_neg_q <= a_sel[W-1];
			b_neg_q <= operand_b[W-1];
			dz_q    <= ((opcode == cia_pkg::OP_DIV) || (opcode == cia_pkg::OP_REM))
			           && (operand_b == '0);
			acc_q   <= (opcode == cia_pkg::OP_MUL) ? a_sel : W'(1);
			base_q  <= a_sel;
			mag_q   <= abs_mag(operand_b);
			quo_q   <= abs_mag(a_sel);
			rem_q   <= '0;
		end else if (cmd.step) begin
			unique case (op_q)
				cia_pkg::OP_MUL: acc_q <= prod[W-1:0];
				cia_pkg::OP_POW: begin
					if (mag_q[0])
						acc_q <= prod[W-1:0];
					base_q <= sq[W-1:0];
					mag_q  <= mag_q >> 1;
				end
				cia_pkg::OP_DIV, cia_pkg::OP_REM: begin
					// restoring step: keep the difference when it does not borrow
					if (!trial[W]) begin
						rem_q <= trial[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= shifted[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (cmd.commit && op_valid) begin
			last_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q    <= res_d;
			res_dz_q <= dz_q;
			res_rc_q <= (op_q == cia_pkg::OP_POW) && b_neg_q;
		end
	end

	assign result      = res_q;
	assign div_by_zero = res_dz_q;
	assign reciprocal  = res_rc_q;

endmodule

// ----- design/cia_ctrl.sv -----
// Controller: sequences load, iteration and write-back, and owns the output valid.
module cia_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output cia_pkg::dp_cmd_t  cmd,
	input  cia_pkg::dp_sts_t  sts
);

	cia_pkg::state_t state_q;
	cia_pkg::state_t state_d;
	logic [cia_pkg::CNT_W-1:0] cnt_q;
	logic out_vld_q;
	logic out_free;

	assign out_free = !out_vld_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cia_pkg::S_IDLE:
				if (req_valid) state_d = cia_pkg::S_CALC;
			cia_pkg::S_CALC:
				if (sts.short_op || (cnt_q == cia_pkg::LAST_STEP)) state_d = cia_pkg::S_WRITE;
			cia_pkg::S_WRITE:
				if (out_free) state_d = cia_pkg::S_IDLE;
			default: state_d = cia_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			cia_pkg::S_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			cia_pkg::S_CALC:  cmd.step   = 1'b1;
			cia_pkg::S_WRITE: cmd.commit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cia_pkg::S_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.step)
				cnt_q <= cnt_q + 1'b1;
			// hold the beat until taken, refill on commit
			if (cmd.commit)
				out_vld_q <= 1'b1;
			else if (!rsp_stall)
				out_vld_q <= 1'b0;
		end
	end

	assign rsp_valid = out_vld_q;

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_vld_q || !rsp_stall))
		else $error("commit overwrote a waiting result");

	a_load_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == cia_pkg::S_CALC) && (cnt_q == '0))
		else $error("load did not start iteration");

	a_long_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cia_pkg::S_CALC && !sts.short_op && cnt_q != cia_pkg::LAST_STEP)
		|=> (state_q == cia_pkg::S_CALC))
		else $error("iteration ended early");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("committed result not presented");

endmodule

// ----- design/chained_integer_alu_unit.sv -----
// Top level: chained integer ALU with add, subtract, multiply, divide, remainder and power.
// Add, subtract, multiply and a zero divisor end iteration after the first step; divide, remainder
// and power run 32 steps of the divider or square-and-multiply. Write-back waits while a result is stalled.
// One item in flight at a time; the result register frees the input for the next request.
// Reset (arst_n low, asynchronous): idle, no result pending, previous result cleared to 0.
module chained_integer_alu_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [2:0]                        opcode,
	input  logic signed [cia_pkg::DATA_W-1:0] operand_a,
	input  logic signed [cia_pkg::DATA_W-1:0] operand_b,
	input  logic                              chain,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic signed [cia_pkg::DATA_W-1:0] result,
	output logic                              div_by_zero,
	output logic                              reciprocal
);

	cia_pkg::dp_cmd_t cmd;
	cia_pkg::dp_sts_t sts;

	cia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	cia_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.chain       (chain),
		.result      (result),
		.div_by_zero (div_by_zero),
		.reciprocal  (reciprocal)
	);

endmodule

// ----- dv/tb_chained_integer_alu_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the chained integer ALU: directed corners, then random beats.
module tb_chained_integer_alu_unit;

	localparam logic [2:0]  OP_SPARE_A   = 3'd6;
	localparam logic [2:0]  OP_SPARE_B   = 3'd7;
	localparam logic [31:0] INT_MIN      = 32'h8000_0000;
	localparam logic [31:0] INT_MAX      = 32'h7fff_ffff;
	localparam logic [31:0] MINUS_ONE    = 32'hffff_ffff;
	localparam int unsigned RANDOM_BEATS = 1050;
	localparam int unsigned HOLD_AFTER   = 600;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned SETTLE       = 40;
	localparam int unsigned IDLE_LIMIT   = 2000;

	typedef struct {
		logic [2:0]  opcode;
		logic [31:0] a;
		logic [31:0] b;
		logic        chain;
		int unsigned gap;
		bit          drain;
	} calc_req_t;

	typedef struct {
		logic [31:0] result;
		logic        dz;
		logic        rc;
	} calc_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [2:0]  opcode = '0;
	logic [31:0] operand_a = '0;
	logic [31:0] operand_b = '0;
	logic        chain = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] result;
	logic        div_by_zero;
	logic        reciprocal;

	calc_req_t   op_queue[$];
	calc_rsp_t   pending_results[$];
	calc_req_t   on_offer;
	logic [31:0] prev_result = '0;
	int unsigned gap_left = 0;
	bit          gap_loaded = 1'b0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	int unsigned rx_wait = 0;
	int unsigned hold_left = 0;
	int unsigned n_results = 0;
	int unsigned n_errors = 0;
	int unsigned idle_cycles = 0;

	chained_integer_alu_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.opcode     (opcode),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.chain      (chain),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.result     (result),
		.div_by_zero(div_by_zero),
		.reciprocal (reciprocal)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out one beat's outcome and advance the running result.
	function automatic calc_rsp_t calc_result(input calc_req_t rq);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic [31:0] base;
		logic [31:0] acc;
		calc_rsp_t   rs;
		x = rq.chain ? prev_result : rq.a;
		y = rq.b;
		rs.result = '0;
		rs.dz = 1'b0;
		rs.rc = 1'b0;
		mag_a = x[31] ? -x : x;
		mag_b = y[31] ? -y : y;
		case (rq.opcode)
			cia_pkg::OP_ADD: rs.result = x + y;
			cia_pkg::OP_SUB: rs.result = x - y;
			cia_pkg::OP_MUL: rs.result = x * y;
			cia_pkg::OP_DIV, cia_pkg::OP_REM: begin
				if (y == '0) begin
					rs.dz = 1'b1;
				end else if (rq.opcode == cia_pkg::OP_DIV) begin
					rs.result = (x[31] ^ y[31]) ? -(mag_a / mag_b) : mag_a / mag_b;
				end else begin
					rs.result = x[31] ? -(mag_a % mag_b) : mag_a % mag_b;
				end
			end
			cia_pkg::OP_POW: begin
				rs.rc = y[31];
				base = x;
				acc = 32'd1;
				for (int i = 0; i < 32; i++) begin
					if (mag_b[i])
						acc = acc * base;
					base = base * base;
				end
				rs.result = acc;
			end
			default: rs.result = prev_result;
		endcase
		// spare opcodes leave the running result alone
		if (rq.opcode <= cia_pkg::OP_POW)
			prev_result = rs.result;
		return rs;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(0, 1) ? 32'd1 : MINUS_ONE;
			2: return $urandom_range(0, 1) ? INT_MIN : INT_MAX;
			3, 4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic void queue_beat(input logic [2:0] op, input logic [31:0] a,
			input logic [31:0] b, input logic ch, input bit drain);
		calc_req_t rq;
		if ($urandom_range(0, 31) == 0)
			tx_quiet = !tx_quiet;
		rq.opcode = op;
		rq.a = a;
		rq.b = b;
		rq.chain = ch;
		rq.gap = tx_quiet ? 0 : $urandom_range(0, 6);
		rq.drain = drain;
		op_queue.push_back(rq);
	endfunction

	// Request side: offer queued beats, predict each one as it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			prev_result = '0;
			gap_left = 0;
			gap_loaded = 1'b0;
		end else begin
			if (req_valid && !req_stall)
				pending_results.push_back(calc_result(on_offer));
			if (!req_valid || !req_stall) begin
				if (op_queue.size() != 0 && !gap_loaded) begin
					gap_left = op_queue[0].gap;
					gap_loaded = 1'b1;
				end
				if (op_queue.size() == 0 || gap_left != 0 ||
				    (op_queue[0].drain && pending_results.size() != 0)) begin
					if (gap_left != 0)
						gap_left--;
					req_valid <= 1'b0;
				end else begin
					on_offer = op_queue.pop_front();
					gap_loaded = 1'b0;
					opcode <= on_offer.opcode;
					operand_a <= on_offer.a;
					operand_b <= on_offer.b;
					chain <= on_offer.chain;
					req_valid <= 1'b1;
				end
			end
		end
	end

	// Response side: check each beat against the oldest prediction, stall at random.
	always @(posedge clk or negedge arst_n) begin
		calc_rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
			n_results = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					$error("result: expected none, got %h", result);
					n_errors++;
				end else begin
					want = pending_results.pop_front();
					if (result !== want.result) begin
						$error("result: expected %h, got %h", want.result, result);
						n_errors++;
					end
					if (div_by_zero !== want.dz) begin
						$error("div_by_zero: expected %b, got %b", want.dz, div_by_zero);
						n_errors++;
					end
					if (reciprocal !== want.rc) begin
						$error("reciprocal: expected %b, got %b", want.rc, reciprocal);
						n_errors++;
					end
				end
				n_results++;
				if ($urandom_range(0, 39) == 0)
					rx_quiet = !rx_quiet;
				rx_wait = rx_quiet ? 0 : $urandom_range(0, 6);
				// long hold-off so the block backs up onto its input
				if (n_results == HOLD_AFTER)
					hold_left = HOLD_CYCLES;
			end else if (rsp_valid && rx_wait != 0) begin
				rx_wait--;
			end
			if (hold_left != 0)
				hold_left--;
			rsp_stall <= (hold_left != 0) || (rx_wait != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [2:0] op;
		// chained first beat picks up the cleared running result
		queue_beat(cia_pkg::OP_ADD, 32'h1234_5678, 32'd5, 1'b1, 1'b0);
		queue_beat(cia_pkg::OP_ADD, INT_MAX, 32'd1, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_SUB, INT_MIN, 32'd1, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_MUL, INT_MAX, INT_MAX, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_MUL, INT_MIN, MINUS_ONE, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_DIV, -32'sd7, 32'd2, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_DIV, 32'd7, -32'sd2, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_REM, -32'sd7, 32'd2, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_REM, 32'd7, -32'sd2, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_DIV, 32'd5, '0, 1'b0, 1'b1);
		queue_beat(cia_pkg::OP_REM, -32'sd5, '0, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_DIV, INT_MIN, MINUS_ONE, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_REM, INT_MIN, MINUS_ONE, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_POW, '0, '0, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_POW, 32'd3, -32'sd2, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_POW, 32'd2, 32'd31, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_POW, 32'd3, INT_MIN, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_POW, MINUS_ONE, INT_MAX, 1'b0, 1'b0);
		queue_beat(OP_SPARE_A, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 1'b0, 1'b0);
		queue_beat(cia_pkg::OP_ADD, 32'hdead_beef, 32'd1, 1'b1, 1'b0);
		queue_beat(cia_pkg::OP_SUB, 32'd9, 32'd100, 1'b0, 1'b0);
		queue_beat(OP_SPARE_B, MINUS_ONE, MINUS_ONE, 1'b1, 1'b0);
		queue_beat(cia_pkg::OP_MUL, '0, -32'sd3, 1'b1, 1'b0);
		queue_beat(cia_pkg::OP_DIV, '0, MINUS_ONE, 1'b1, 1'b0);
		queue_beat(cia_pkg::OP_SUB, '0, INT_MIN, 1'b0, 1'b0);
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if ($urandom_range(0, 99) < 2)
				op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
			else
				op = 3'($urandom_range(0, 5));
			queue_beat(op, pick_operand(), pick_operand(), 1'($urandom_range(0, 1)),
				i == 0 || i == 300 || i == 800);
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (op_queue.size() != 0 || req_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- chained_integer_alu_unit.f -----
design/cia_pkg.sv
design/cia_dp.sv
design/cia_ctrl.sv
design/chained_integer_alu_unit.sv
dv/tb_chained_integer_alu_unit.sv
